// File: hw/rtl/dttu_pkg.sv
// Shared types and constants for the decimal text to uint64 reader.
`default_nettype none
package dttu_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  // Sum width for value*10+digit: four extra bits catch any carry past 2^64-1.
  localparam int unsigned SumW    = ValueW + 4;

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_TOOBIG = 2'd1,
    ST_EOI    = 2'd2
  } status_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_t           status;
    logic              consumed;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] char_byte;
    logic             end_of_input;
  } in_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/dttu_in_stage.sv
// Input register stage: holds one accepted word until the parser takes it.
`default_nettype none
module dttu_in_stage
  import dttu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] in_char_byte,
  input  wire logic             in_end_of_input,
  input  wire logic             adv,
  output logic                  word_valid,
  output in_word_t              word
);

  logic     valid_r;
  in_word_t word_r;

  // Stall only when a word is held and the parser cannot take it.
  assign in_stall   = valid_r && !adv;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r.char_byte    <= in_char_byte;
      word_r.end_of_input <= in_end_of_input;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dttu_parse.sv
// Parser state and combinational step logic: whitespace, sign, digit accumulation.
`default_nettype none
module dttu_parse
  import dttu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_word_t word,
  output logic          res_valid,
  output result_t       res
);

  phase_t            phase_r, phase_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [SumW-1:0]   sum;
  logic              in_digits, after_sign, is_space, is_plus, is_digit;

  assign in_digits  = (phase_r == PH_DIGITS);
  assign after_sign = (phase_r == PH_SIGN);
  assign is_space   = (word.char_byte == ChSpace) || (word.char_byte == ChTab) ||
                      (word.char_byte == ChCr) || (word.char_byte == ChLf);
  assign is_plus    = (word.char_byte == ChPlus);
  assign is_digit   = (word.char_byte >= ChZero) && (word.char_byte <= ChNine);

  // value*10 + digit as (v<<3)+(v<<1)+d; any bit above 63 is overflow.
  assign sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
               {{(SumW-4){1'b0}}, word.char_byte[3:0]};

  always_comb begin
    res_valid    = 1'b0;
    res.value    = '0;
    res.status   = ST_OK;
    res.consumed = 1'b0;
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    priority if (word.end_of_input) begin
      res_valid = 1'b1;
      if (in_digits) begin
        res.value = acc_r;
      end else begin
        res.status = ST_EOI;
      end
    end else if (!in_digits && !after_sign && is_space) begin
      // drop leading whitespace
    end else if (!in_digits && !after_sign && is_plus) begin
      phase_nxt = PH_SIGN;
    end else if (is_digit) begin
      if (sum[SumW-1:ValueW] != '0) begin
        res_valid    = 1'b1;
        res.status   = ST_TOOBIG;
        res.consumed = 1'b1;
      end else begin
        acc_nxt   = sum[ValueW-1:0];
        phase_nxt = PH_DIGITS;
      end
    end else begin
      // non-digit ends the number; push the byte back
      res_valid = 1'b1;
      res.value = in_digits ? acc_r : '0;
    end
    if (res_valid) begin
      phase_nxt = PH_SKIP;
      acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      acc_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> (phase_r == PH_SKIP) && (acc_r == '0))
    else $error("parser state not cleared after a result");

  a_acc_only_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r != '0) |-> (phase_r == PH_DIGITS))
    else $error("nonzero value outside digit phase");

  a_toobig_form: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && (res.status == ST_TOOBIG) |-> res.consumed && (res.value == '0))
    else $error("overflow result malformed");

endmodule
`default_nettype wire

// File: hw/rtl/dttu_out_stage.sv
// Result register: holds one result word until the receiver takes it.
`default_nettype none
module dttu_out_stage
  import dttu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic               res_valid,
  input  wire result_t            res,
  output logic                    adv,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ValueW-1:0]       out_number_value,
  output logic [StatusW-1:0]      out_status,
  output logic                    out_byte_consumed
);

  logic    valid_r;
  result_t res_r;

  // The slot is free when empty or being taken this cycle.
  assign adv               = !valid_r || !out_stall;
  assign out_valid         = valid_r;
  assign out_number_value  = res_r.value;
  assign out_status        = res_r.status;
  assign out_byte_consumed = res_r.consumed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/decimal_text_to_uint64_top.sv
// Top level of the decimal text to uint64 reader.
//
// Input channel (in_valid / in_stall): one word per handshake, a character byte
// plus an end_of_input flag; the byte is ignored when end_of_input is set.
// Result channel (out_valid / out_stall): one word per finished number with the
// value, a status (ok, too big, end of input before number) and whether the
// terminating byte was eaten. Most input words give no result.
// Throughput: one input word per cycle unless out_stall holds back a result,
// with the parser step (a 68-bit three-operand add for value*10+digit)
// combinational between two registers. The word that ends a number passes the
// input register, then the result register, whose load raises out_valid.
// Reset (rst_n low, synchronous): both registers empty, parser back in the
// whitespace phase with a cleared value.
// Stall: while out_stall holds a pending result, the parser freezes and the
// input register stalls the sender once it is full; words are never dropped.
`default_nettype none
module decimal_text_to_uint64_top
  import dttu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ByteW-1:0]   in_char_byte,
  input  wire logic               in_end_of_input,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ValueW-1:0]       out_number_value,
  output logic [StatusW-1:0]      out_status,
  output logic                    out_byte_consumed
);

  logic     adv;
  logic     word_valid;
  in_word_t word;
  logic     fire;
  logic     res_valid;
  result_t  res;

  // Advance the held word into the parser when the result slot can take it.
  assign fire = word_valid && adv;

  dttu_in_stage u_in (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_char_byte,
    .in_end_of_input,
    .adv,
    .word_valid,
    .word
  );

  dttu_parse u_parse (
    .clk,
    .rst_n,
    .fire,
    .word,
    .res_valid,
    .res
  );

  dttu_out_stage u_out (
    .clk,
    .rst_n,
    .fire,
    .res_valid,
    .res,
    .adv,
    .out_valid,
    .out_stall,
    .out_number_value,
    .out_status,
    .out_byte_consumed
  );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the decimal text to uint64 reader.
`timescale 1ns / 1ps
module testbench;
  import dttu_pkg::*;

  // Run length and pacing.
  localparam int unsigned StreamWords = 1900;
  localparam int unsigned HoldStart   = 800;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DirRows     = 26;

  localparam logic [ValueW-1:0] MaxValue = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] MaxDiv10 = 64'h1999_9999_9999_9999;

  // One stimulus word plus an optional typed-in expectation.
  typedef struct packed {
    logic [ByteW-1:0] char_byte;
    logic             end_of_input;
    logic             typed;
    result_t          want;
  } text_row_t;

  localparam result_t NoResult   = '0;
  localparam result_t EoiNothing = '{value: '0, status: ST_EOI, consumed: 1'b0};
  localparam result_t ZeroOk     = '{value: '0, status: ST_OK, consumed: 1'b0};

  // Directed table: typed-in expectations only where they are obvious;
  // all other rows go through the parse predictor.
  text_row_t directed_rows [DirRows] = '{
    '{8'hFF,   1'b1, 1'b1, EoiNothing}, // end of input right after reset
    '{ChSpace, 1'b0, 1'b0, NoResult},
    '{ChTab,   1'b0, 1'b0, NoResult},
    '{ChCr,    1'b0, 1'b0, NoResult},
    '{ChLf,    1'b0, 1'b0, NoResult},
    '{ChPlus,  1'b0, 1'b0, NoResult},
    '{8'h00,   1'b1, 1'b1, EoiNothing}, // end of input right after the sign
    '{ChPlus,  1'b0, 1'b0, NoResult},
    '{ChPlus,  1'b0, 1'b1, ZeroOk},     // second sign ends an empty number
    '{8'h41,   1'b0, 1'b1, ZeroOk},     // letter while skipping
    '{ChPlus,  1'b0, 1'b0, NoResult},
    '{8'hFF,   1'b0, 1'b1, ZeroOk},     // non-digit right after the sign
    '{ChNine,  1'b0, 1'b0, NoResult},
    '{ChNine,  1'b0, 1'b0, NoResult},
    '{8'h00,   1'b1, 1'b0, NoResult},   // end of input after digits
    '{ChZero,  1'b0, 1'b0, NoResult},
    '{8'h2F,   1'b0, 1'b0, NoResult},   // just below the digit range
    '{8'h31,   1'b0, 1'b0, NoResult},
    '{8'h32,   1'b0, 1'b0, NoResult},
    '{8'h3A,   1'b0, 1'b0, NoResult},   // just above the digit range
    '{8'h35,   1'b0, 1'b0, NoResult},
    '{ChPlus,  1'b0, 1'b0, NoResult},   // sign after digits ends the number
    '{8'h37,   1'b0, 1'b0, NoResult},
    '{ChSpace, 1'b0, 1'b0, NoResult},   // whitespace after digits ends it too
    '{ChZero,  1'b0, 1'b0, NoResult},
    '{8'h80,   1'b1, 1'b0, NoResult}    // zero closed by end of input
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ByteW-1:0] in_char_byte = '0;
  logic in_end_of_input = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ValueW-1:0] out_number_value;
  logic [StatusW-1:0] out_status;
  logic out_byte_consumed;

  // Predictor state: a private copy of the parser.
  phase_t            parse_phase = PH_SKIP;
  logic [ValueW-1:0] acc_value = '0;

  text_row_t   stream_rows [$];
  result_t     pending_numbers [$];
  int unsigned accepted_words = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned counted_words = 0;
  logic        hold_rx = 1'b0;

  decimal_text_to_uint64_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_byte      (in_char_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_number_value  (out_number_value),
    .out_status        (out_status),
    .out_byte_consumed (out_byte_consumed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Advance the parse predictor by one word; return 1 when a number closes.
  function automatic bit parse_word(input logic [ByteW-1:0] ch, input logic eoi,
                                    output result_t res);
    logic [ValueW-1:0] digit;
    bit                done;
    bit                skipping;
    res      = '0;
    res.status = ST_OK;
    done     = 1'b0;
    skipping = (parse_phase != PH_DIGITS) && (parse_phase != PH_SIGN);
    digit    = ValueW'(ch - ChZero);
    if (eoi) begin
      done = 1'b1;
      if (parse_phase == PH_DIGITS) begin
        res.value = acc_value;
      end else begin
        res.status = ST_EOI;
      end
    end else if (skipping && (ch == ChSpace || ch == ChTab || ch == ChCr || ch == ChLf)) begin
      // eat whitespace, nothing to report
    end else if (skipping && ch == ChPlus) begin
      parse_phase = PH_SIGN;
    end else if (ch >= ChZero && ch <= ChNine) begin
      if (acc_value > MaxDiv10 || acc_value * 64'd10 > MaxValue - digit) begin
        done         = 1'b1;
        res.status   = ST_TOOBIG;
        res.consumed = 1'b1;
      end else begin
        acc_value   = acc_value * 64'd10 + digit;
        parse_phase = PH_DIGITS;
      end
    end else begin
      // any other byte closes the number and is pushed back
      done = 1'b1;
      if (parse_phase == PH_DIGITS) begin
        res.value = acc_value;
      end
    end
    if (done) begin
      parse_phase = PH_SKIP;
      acc_value   = '0;
    end
    return done;
  endfunction

  // Stream building helpers.
  task automatic add_byte(input logic [ByteW-1:0] ch);
    stream_rows.push_back('{ch, 1'b0, 1'b0, NoResult});
    counted_words++;
  endtask

  task automatic add_eoi();
    stream_rows.push_back('{ByteW'($urandom_range(255)), 1'b1, 1'b0, NoResult});
    counted_words++;
  endtask

  function automatic logic [ByteW-1:0] blank_byte();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      default: return ChLf;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] stop_byte();
    logic [ByteW-1:0] b;
    if ($urandom_range(99) < 30) begin
      return ($urandom_range(1) != 0) ? ChPlus : blank_byte();
    end
    do begin
      b = ByteW'($urandom_range(255));
    end while (b >= ChZero && b <= ChNine);
    return b;
  endfunction

  function automatic logic [ByteW-1:0] digit_byte();
    return ChZero + ByteW'($urandom_range(9));
  endfunction

  // Random part: mostly well-formed numbers, some noise and broken sequences.
  task automatic build_random_stream();
    string       limit_text;
    int unsigned kind;
    int unsigned n;
    limit_text = "18446744073709551615";
    while (counted_words < StreamWords) begin
      kind = $urandom_range(99);
      if (kind < 62) begin
        repeat ($urandom_range(2)) add_byte(blank_byte());
        if ($urandom_range(99) < 40) add_byte(ChPlus);
        case ($urandom_range(9))
          0: begin
            // walk the 2^64-1 boundary: last digit decides fit or overflow
            for (int i = 0; i < 19; i++) add_byte(limit_text[i]);
            add_byte(digit_byte());
            if ($urandom_range(99) < 30) add_byte(digit_byte());
          end
          1: begin
            repeat ($urandom_range(22, 1)) add_byte(ChZero);
            repeat ($urandom_range(3, 1)) add_byte(digit_byte());
          end
          2: begin
            repeat ($urandom_range(23, 20)) add_byte(digit_byte());
          end
          default: begin
            n = ($urandom_range(3) == 0) ? $urandom_range(19, 1) : $urandom_range(6, 1);
            repeat (n) add_byte(digit_byte());
          end
        endcase
        if ($urandom_range(99) < 25) add_eoi();
        else add_byte(stop_byte());
      end else if (kind < 77) begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(9) == 0) add_eoi();
          else add_byte(ByteW'($urandom_range(255)));
        end
      end else if (kind < 92) begin
        case ($urandom_range(3))
          0: begin add_byte(ChPlus); add_byte(stop_byte()); end
          1: begin add_byte(ChPlus); add_byte(ChPlus); end
          2: begin add_byte(ChPlus); add_eoi(); end
          default: begin add_byte(blank_byte()); add_eoi(); end
        endcase
      end else begin
        add_eoi();
      end
    end
  endtask

  // Gap length: mostly none, often short, a few long.
  task automatic n_gap_pick(output int unsigned len);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) len = 0;
    else if (r < 96) len = $urandom_range(3, 1);
    else len = $urandom_range(30, 8);
  endtask

  // Build the whole stream, then hold reset for a while and release it.
  initial begin
    for (int i = 0; i < DirRows; i++) stream_rows.push_back(directed_rows[i]);
    build_random_stream();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: offer words in order, hold a stalled word steady, insert random
  // gaps with occasional gap-free stretches.
  int unsigned send_idx = 0;
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_char_byte    <= '0;
      in_end_of_input <= 1'b0;
    end else begin
      if (in_valid && !in_stall) send_idx++;
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (send_idx < stream_rows.size()) begin
          in_valid        <= 1'b1;
          in_char_byte    <= stream_rows[send_idx].char_byte;
          in_end_of_input <= stream_rows[send_idx].end_of_input;
          if (tx_calm != 0) begin
            tx_calm--;
          end else if ($urandom_range(99) == 0) begin
            tx_calm = $urandom_range(120, 40);
          end else begin
            n_gap_pick(tx_gap);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall stretches, plus the long hold-off below.
  int unsigned rx_left = 0;
  int unsigned rx_calm = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_calm != 0) begin
        rx_calm--;
      end else if ($urandom_range(99) == 0) begin
        rx_calm = $urandom_range(120, 40);
      end else begin
        n_gap_pick(rx_left);
      end
      out_stall <= hold_rx || (rx_left != 0);
    end
  end

  // Long hold-off: keep the result side stalled while words keep coming, so
  // the block fills and stalls its input.
  initial begin
    while (!(rst_n && accepted_words >= HoldStart)) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Scoreboard: check the result first (it always belongs to an older word),
  // then predict from the word accepted at this edge.
  always @(posedge clk) begin
    result_t   want;
    result_t   guess;
    text_row_t row;
    bit        closes;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_numbers.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result value=%0d status=%0d consumed=%0d", $time,
                   out_number_value, out_status, out_byte_consumed);
        end else begin
          want = pending_numbers.pop_front();
          if (out_number_value !== want.value) begin
            mismatches++;
            $display("%0t: value expected %0d actual %0d", $time, want.value,
                     out_number_value);
          end
          if (out_status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
          if (out_byte_consumed !== want.consumed) begin
            mismatches++;
            $display("%0t: consumed expected %0d actual %0d", $time, want.consumed,
                     out_byte_consumed);
          end
        end
      end
      if (in_valid && !in_stall) begin
        row    = stream_rows[accepted_words];
        closes = parse_word(row.char_byte, row.end_of_input, guess);
        if (row.typed) pending_numbers.push_back(row.want);
        else if (closes) pending_numbers.push_back(guess);
        accepted_words++;
      end
    end
  end

  // Drain: wait for every word and every expected number, then keep watching
  // for DrainCycles more to catch stray results.
  initial begin
    while (!(rst_n && accepted_words == stream_rows.size() && pending_numbers.size() == 0))
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_numbers.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, pending_numbers.size());
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
